// ===== hw/rtl/sgi_pkg.sv =====
`default_nettype none
package sgi_pkg;

   // coordinate width; every other width follows from it
   localparam int COORD_BITS = 16;

   localparam int AW  = COORD_BITS + 1;         // a, b line terms
   localparam int PW  = 2 * COORD_BITS;         // coordinate products
   localparam int CW  = 2 * COORD_BITS + 1;     // c line terms
   localparam int DPW = 2 * COORD_BITS + 2;     // a*b products
   localparam int DW  = 2 * COORD_BITS + 3;     // determinant
   localparam int NPW = 3 * COORD_BITS + 2;     // c*b and a*c products
   localparam int NW  = 3 * COORD_BITS + 3;     // numerators and quotients
   localparam int RW  = DW + 1;                 // divider partial remainder
   localparam int EW  = COORD_BITS + 3;         // segment test width

   localparam logic [1:0] OUT_PARALLEL = 2'd0;
   localparam logic [1:0] OUT_CROSS    = 2'd1;
   localparam logic [1:0] OUT_HIT      = 2'd2;

   typedef struct packed {
      logic signed [COORD_BITS-1:0] x1;
      logic signed [COORD_BITS-1:0] y1;
      logic signed [COORD_BITS-1:0] x2;
      logic signed [COORD_BITS-1:0] y2;
      logic signed [COORD_BITS-1:0] x3;
      logic signed [COORD_BITS-1:0] y3;
      logic signed [COORD_BITS-1:0] x4;
      logic signed [COORD_BITS-1:0] y4;
   } coord_set_type;

   typedef struct packed {
      logic [RW-1:0] rem;
      logic [NW-1:0] num;
      logic [NW-1:0] quo;
      logic          neg;
   } div_lane_type;

   typedef struct packed {
      coord_set_type pts;
      logic          par;
      logic [DW-1:0] den;
   } div_side_type;

   typedef struct packed {
      div_lane_type lx;
      div_lane_type ly;
      div_side_type side;
   } div_item_type;

endpackage
`default_nettype wire

// ===== hw/rtl/sgi_req_if.sv =====
`default_nettype none
interface sgi_req_if import sgi_pkg::*; ;
   logic valid;
   logic ready;
   logic signed [COORD_BITS-1:0] ax;
   logic signed [COORD_BITS-1:0] ay;
   logic signed [COORD_BITS-1:0] bx;
   logic signed [COORD_BITS-1:0] by_coord;
   logic signed [COORD_BITS-1:0] cx;
   logic signed [COORD_BITS-1:0] cy;
   logic signed [COORD_BITS-1:0] dx;
   logic signed [COORD_BITS-1:0] dy;

   modport source (output valid, ax, ay, bx, by_coord, cx, cy, dx, dy, input ready);
   modport sink (input valid, ax, ay, bx, by_coord, cx, cy, dx, dy, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/sgi_rsp_if.sv =====
`default_nettype none
interface sgi_rsp_if import sgi_pkg::*; ;
   logic valid;
   logic ready;
   logic signed [COORD_BITS-1:0] cross_x;
   logic signed [COORD_BITS-1:0] cross_y;
   logic [1:0] outcome;
   logic clipped;

   modport source (output valid, cross_x, cross_y, outcome, clipped, input ready);
   modport sink (input valid, cross_x, cross_y, outcome, clipped, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/sgi_front.sv =====
`default_nettype none
module sgi_front import sgi_pkg::*; (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          adv,
   input  wire logic          in_valid,
   input  wire coord_set_type in_pts,
   output logic               out_valid,
   output div_item_type       out_item
);

   logic v1_ff, v2_ff, v3_ff, v4_ff;
   coord_set_type pts1_ff, pts2_ff, pts3_ff;

   // stage one: line terms and coordinate products
   logic signed [AW-1:0] a1_ff, b1_ff, a2_ff, b2_ff;
   logic signed [AW-1:0] a1_in, b1_in, a2_in, b2_in;
   logic signed [PW-1:0] p12_ff, p21_ff, p34_ff, p43_ff;
   logic signed [PW-1:0] p12_in, p21_in, p34_in, p43_in;

   assign a1_in  = AW'(in_pts.y2) - AW'(in_pts.y1);
   assign b1_in  = AW'(in_pts.x1) - AW'(in_pts.x2);
   assign a2_in  = AW'(in_pts.y4) - AW'(in_pts.y3);
   assign b2_in  = AW'(in_pts.x3) - AW'(in_pts.x4);
   assign p12_in = PW'(in_pts.x1) * PW'(in_pts.y2);
   assign p21_in = PW'(in_pts.x2) * PW'(in_pts.y1);
   assign p34_in = PW'(in_pts.x3) * PW'(in_pts.y4);
   assign p43_in = PW'(in_pts.x4) * PW'(in_pts.y3);

   // stage two: c terms and determinant products
   logic signed [AW-1:0]  a1s_ff, b1s_ff, a2s_ff, b2s_ff;
   logic signed [CW-1:0]  c1_ff, c2_ff, c1_in, c2_in;
   logic signed [DPW-1:0] d1_ff, d2_ff, d1_in, d2_in;

   assign c1_in = CW'(p12_ff) - CW'(p21_ff);
   assign c2_in = CW'(p34_ff) - CW'(p43_ff);
   assign d1_in = DPW'(a1_ff) * DPW'(b2_ff);
   assign d2_in = DPW'(a2_ff) * DPW'(b1_ff);

   // stage three: determinant and numerator products
   logic signed [DW-1:0]  det_ff, det_in;
   logic signed [NPW-1:0] m1_ff, m2_ff, m3_ff, m4_ff;
   logic signed [NPW-1:0] m1_in, m2_in, m3_in, m4_in;

   assign det_in = DW'(d1_ff) - DW'(d2_ff);
   assign m1_in  = NPW'(c1_ff) * NPW'(b2s_ff);
   assign m2_in  = NPW'(c2_ff) * NPW'(b1s_ff);
   assign m3_in  = NPW'(a1s_ff) * NPW'(c2_ff);
   assign m4_in  = NPW'(a2s_ff) * NPW'(c1_ff);

   // stage four: numerators, magnitudes and quotient signs
   logic signed [NW-1:0] nx, ny;
   div_item_type item_ff, item_in;

   assign nx = NW'(m1_ff) - NW'(m2_ff);
   assign ny = NW'(m3_ff) - NW'(m4_ff);

   always_comb begin
      item_in          = '0;
      item_in.lx.num   = nx[NW-1] ? NW'(-nx) : NW'(nx);
      item_in.ly.num   = ny[NW-1] ? NW'(-ny) : NW'(ny);
      item_in.lx.neg   = nx[NW-1] ^ det_ff[DW-1];
      item_in.ly.neg   = ny[NW-1] ^ det_ff[DW-1];
      item_in.side.pts = pts3_ff;
      item_in.side.par = (det_ff == '0);
      item_in.side.den = det_ff[DW-1] ? DW'(-det_ff) : DW'(det_ff);
   end

   // advance valid bits with the pipeline
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else if (adv) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
      end
   end

   // advance payload
   always_ff @(posedge clock) begin
      if (adv) begin
         pts1_ff <= in_pts;
         a1_ff   <= a1_in;
         b1_ff   <= b1_in;
         a2_ff   <= a2_in;
         b2_ff   <= b2_in;
         p12_ff  <= p12_in;
         p21_ff  <= p21_in;
         p34_ff  <= p34_in;
         p43_ff  <= p43_in;

         pts2_ff <= pts1_ff;
         a1s_ff  <= a1_ff;
         b1s_ff  <= b1_ff;
         a2s_ff  <= a2_ff;
         b2s_ff  <= b2_ff;
         c1_ff   <= c1_in;
         c2_ff   <= c2_in;
         d1_ff   <= d1_in;
         d2_ff   <= d2_in;

         pts3_ff <= pts2_ff;
         det_ff  <= det_in;
         m1_ff   <= m1_in;
         m2_ff   <= m2_in;
         m3_ff   <= m3_in;
         m4_ff   <= m4_in;

         item_ff <= item_in;
      end
   end

   assign out_valid = v4_ff;
   assign out_item  = item_ff;

endmodule
`default_nettype wire

// ===== hw/rtl/sgi_div_cell.sv =====
`default_nettype none
module sgi_div_cell import sgi_pkg::*; (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         adv,
   input  wire logic         in_valid,
   input  wire div_item_type in_item,
   output logic              out_valid,
   output div_item_type      out_item
);

   // one restoring division step: shift in the next numerator bit
   function automatic div_lane_type div_step(div_lane_type l, logic [DW-1:0] d);
      div_lane_type r;
      logic [RW-1:0] trial;
      logic          take;
      trial = {l.rem[RW-2:0], l.num[NW-1]};
      take  = (trial >= {1'b0, d});
      r     = l;
      r.rem = take ? (trial - {1'b0, d}) : trial;
      r.num = {l.num[NW-2:0], 1'b0};
      r.quo = {l.quo[NW-2:0], take};
      return r;
   endfunction

   logic         valid_ff;
   div_item_type item_ff, item_in;

   always_comb begin
      item_in    = in_item;
      item_in.lx = div_step(in_item.lx, in_item.side.den);
      item_in.ly = div_step(in_item.ly, in_item.side.den);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (adv) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         item_ff <= item_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_item  = item_ff;

endmodule
`default_nettype wire

// ===== hw/rtl/segment_intersection_unit.sv =====
// Pipeline: 4 front stages, one divider cell per quotient bit (3*COORD_BITS+3)
// and 1 output register.
// Throughput: one item per cycle; the whole pipeline holds while a result waits.
// Reset: synchronous, active high; clears the valid bits only, no datapath state.
`default_nettype none
module segment_intersection_unit import sgi_pkg::*; (
   input wire logic clock,
   input wire logic reset,
   sgi_req_if.sink  req,
   sgi_rsp_if.source rsp
);

   logic adv;
   coord_set_type in_pts;

   logic         chain_valid [NW+1];
   div_item_type chain_item [NW+1];

   logic rsp_valid_ff;

   // move everything when the output register is free or being emptied
   assign adv       = !rsp_valid_ff || rsp.ready;
   assign req.ready = adv;

   assign in_pts.x1 = req.ax;
   assign in_pts.y1 = req.ay;
   assign in_pts.x2 = req.bx;
   assign in_pts.y2 = req.by_coord;
   assign in_pts.x3 = req.cx;
   assign in_pts.y3 = req.cy;
   assign in_pts.x4 = req.dx;
   assign in_pts.y4 = req.dy;

   sgi_front u_front (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (req.valid),
      .in_pts    (in_pts),
      .out_valid (chain_valid[0]),
      .out_item  (chain_item[0])
   );

   // divider chain, one quotient bit per cell
   for (genvar i = 0; i < NW; i++) begin : g_cell
      sgi_div_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .adv       (adv),
         .in_valid  (chain_valid[i]),
         .in_item   (chain_item[i]),
         .out_valid (chain_valid[i+1]),
         .out_item  (chain_item[i+1])
      );
   end

   // |2x - (p+q)| <= |q - p|
   function automatic logic seg_within(logic signed [COORD_BITS-1:0] x,
                                       logic signed [COORD_BITS-1:0] p,
                                       logic signed [COORD_BITS-1:0] q);
      logic signed [EW-1:0] dev;
      logic signed [EW-1:0] span;
      dev  = (EW'(x) + EW'(x)) - (EW'(p) + EW'(q));
      span = EW'(q) - EW'(p);
      if (dev[EW-1]) dev = -dev;
      if (span[EW-1]) span = -span;
      return (dev <= span);
   endfunction

   localparam logic [NW-1:0] LIM = NW'(1) << (COORD_BITS - 1);
   localparam logic signed [COORD_BITS-1:0] CMAX = {1'b0, {(COORD_BITS-1){1'b1}}};
   localparam logic signed [COORD_BITS-1:0] CMIN = {1'b1, {(COORD_BITS-1){1'b0}}};

   div_item_type fin;
   logic over_x, over_y;
   logic signed [COORD_BITS-1:0] vx, vy, sx, sy;
   logic hit;

   logic signed [COORD_BITS-1:0] cross_x_ff, cross_x_in;
   logic signed [COORD_BITS-1:0] cross_y_ff, cross_y_in;
   logic [1:0] outcome_ff, outcome_in;
   logic clipped_ff, clipped_in;

   assign fin = chain_item[NW];

   // sign the quotients and saturate to the coordinate range
   always_comb begin
      over_x = fin.lx.neg ? (fin.lx.quo > LIM) : (fin.lx.quo >= LIM);
      over_y = fin.ly.neg ? (fin.ly.quo > LIM) : (fin.ly.quo >= LIM);
      vx = fin.lx.neg ? -$signed(fin.lx.quo[COORD_BITS-1:0])
                      : $signed(fin.lx.quo[COORD_BITS-1:0]);
      vy = fin.ly.neg ? -$signed(fin.ly.quo[COORD_BITS-1:0])
                      : $signed(fin.ly.quo[COORD_BITS-1:0]);
      sx = over_x ? (fin.lx.neg ? CMIN : CMAX) : vx;
      sy = over_y ? (fin.ly.neg ? CMIN : CMAX) : vy;
      // a crossing outside the range can never lie on a segment
      hit = !over_x && !over_y &&
            seg_within(vx, fin.side.pts.x1, fin.side.pts.x2) &&
            seg_within(vy, fin.side.pts.y1, fin.side.pts.y2) &&
            seg_within(vx, fin.side.pts.x3, fin.side.pts.x4) &&
            seg_within(vy, fin.side.pts.y3, fin.side.pts.y4);
      if (fin.side.par) begin
         cross_x_in = '0;
         cross_y_in = '0;
         outcome_in = OUT_PARALLEL;
         clipped_in = 1'b0;
      end else begin
         cross_x_in = sx;
         cross_y_in = sy;
         outcome_in = hit ? OUT_HIT : OUT_CROSS;
         clipped_in = over_x || over_y;
      end
   end

   // hold the result until it is taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= chain_valid[NW];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         cross_x_ff <= cross_x_in;
         cross_y_ff <= cross_y_in;
         outcome_ff <= outcome_in;
         clipped_ff <= clipped_in;
      end
   end

   assign rsp.valid   = rsp_valid_ff;
   assign rsp.cross_x = cross_x_ff;
   assign rsp.cross_y = cross_y_ff;
   assign rsp.outcome = outcome_ff;
   assign rsp.clipped = clipped_ff;

endmodule
`default_nettype wire

// ===== bench/tb_segment_intersection_unit.sv =====
`default_nettype none
module tb_segment_intersection_unit;
   import sgi_pkg::*;

   typedef logic signed [COORD_BITS-1:0] coord_type;
   typedef logic signed [127:0] wide_type;

   typedef struct packed {
      coord_type ax, ay, bx, by_coord, cx, cy, dx, dy;
   } seg_pair_type;

   typedef struct packed {
      coord_type  cross_x;
      coord_type  cross_y;
      logic [1:0] outcome;
      logic       clipped;
   } crossing_type;

   localparam int CYCLE_LIMIT = 400000;
   localparam int DRAIN_CYCLES = 80;

   logic clock = 1'b0;
   logic reset = 1'b1;
   int   cycle_count = 0;
   int   error_count = 0;
   bit   stim_done = 1'b0;
   int   hold_off = 0;

   seg_pair_type pending_pairs[$];
   crossing_type expected_crossings[$];

   sgi_req_if req();
   sgi_rsp_if rsp();

   segment_intersection_unit i_dut (
      .clock(clock),
      .reset(reset),
      .req(req.sink),
      .rsp(rsp.source)
   );

   always #1 clock = ~clock;

   // |2x - (p+q)| <= |q - p|
   function automatic bit on_span(wide_type x, wide_type p, wide_type q);
      wide_type dev, span;
      dev = 2 * x - (p + q);
      span = q - p;
      if (dev < 0) dev = -dev;
      if (span < 0) span = -span;
      return dev <= span;
   endfunction

   function automatic coord_type saturate(wide_type v, inout bit clip);
      wide_type top, bot;
      top = (wide_type'(1) <<< (COORD_BITS - 1)) - 1;
      bot = -top - 1;
      if (v > top) begin
         clip = 1'b1;
         return coord_type'(top);
      end
      if (v < bot) begin
         clip = 1'b1;
         return coord_type'(bot);
      end
      return coord_type'(v);
   endfunction

   // Cramer's rule on the two line equations, quotient truncated toward zero
   function automatic crossing_type predict_crossing(seg_pair_type s);
      wide_type x1, y1, x2, y2, x3, y3, x4, y4;
      wide_type a1, b1, c1, a2, b2, c2, det, px, py;
      crossing_type r;
      bit clip;
      bit hit;
      x1 = s.ax; y1 = s.ay; x2 = s.bx; y2 = s.by_coord;
      x3 = s.cx; y3 = s.cy; x4 = s.dx; y4 = s.dy;
      a1 = y2 - y1; b1 = x1 - x2; c1 = x1 * y2 - x2 * y1;
      a2 = y4 - y3; b2 = x3 - x4; c2 = x3 * y4 - x4 * y3;
      det = a1 * b2 - a2 * b1;
      r = '0;
      clip = 1'b0;
      if (det == 0) begin
         r.outcome = OUT_PARALLEL;
         return r;
      end
      px = (c1 * b2 - c2 * b1) / det;
      py = (a1 * c2 - a2 * c1) / det;
      hit = on_span(px, x1, x2) && on_span(py, y1, y2) &&
            on_span(px, x3, x4) && on_span(py, y3, y4);
      r.cross_x = saturate(px, clip);
      r.cross_y = saturate(py, clip);
      r.outcome = hit ? OUT_HIT : OUT_CROSS;
      r.clipped = clip;
      return r;
   endfunction

   function automatic coord_type rand_coord(int mode);
      case (mode)
         0: return coord_type'($urandom);
         1: return coord_type'($urandom_range(0, 2047)) - coord_type'(1024);
         default: return coord_type'($urandom_range(0, 63)) - coord_type'(32);
      endcase
   endfunction

   function automatic seg_pair_type make_pair(coord_type a0, coord_type a1, coord_type a2,
                                              coord_type a3, coord_type a4, coord_type a5,
                                              coord_type a6, coord_type a7);
      seg_pair_type s;
      s.ax = a0; s.ay = a1; s.bx = a2; s.by_coord = a3;
      s.cx = a4; s.cy = a5; s.dx = a6; s.dy = a7;
      return s;
   endfunction

   // fill the item queue: directed corners, then random pairs
   initial begin
      seg_pair_type s;
      coord_type mx, mn;
      int mode;
      mx = coord_type'(16'sh7fff);
      mn = coord_type'(16'sh8000);
      // crossing segments, lines crossing off a segment
      pending_pairs.push_back(make_pair(0, 0, 160, 160, 0, 160, 160, 0));
      pending_pairs.push_back(make_pair(0, 0, 16, 16, 0, 160, 160, 0));
      // parallel and degenerate
      pending_pairs.push_back(make_pair(0, 0, 16, 16, 16, 0, 32, 16));
      pending_pairs.push_back(make_pair(5, 5, 5, 5, 0, 0, 16, 32));
      pending_pairs.push_back(make_pair(0, 0, 0, 0, 0, 0, 0, 0));
      // extremes, clipping
      pending_pairs.push_back(make_pair(mn, mn, mx, mx, mn, mx, mx, mn));
      pending_pairs.push_back(make_pair(mx, mx, mn, mn, mx, mn, mn, mx));
      pending_pairs.push_back(make_pair(mn, mn, mn, mx, mx, mn, coord_type'(16'sh7ffe), mx));
      pending_pairs.push_back(make_pair(0, 0, 1, 0, mx, 0, mx, 1));
      pending_pairs.push_back(make_pair(0, 0, 1, 1, 0, 1, 1, 3));
      pending_pairs.push_back(make_pair(-1, -1, 1, 1, -1, 1, 1, -1));
      pending_pairs.push_back(make_pair(mx, mn, mn, mx, -1, -1, 1, 1));
      // shared endpoint, negative quotients
      pending_pairs.push_back(make_pair(0, 0, 32, 0, 32, 0, 32, 32));
      pending_pairs.push_back(make_pair(-3, 7, 11, -5, 2, -9, -6, 13));
      repeat (900) begin
         mode = $urandom_range(0, 3);
         s = make_pair(rand_coord(mode), rand_coord(mode), rand_coord(mode),
                       rand_coord(mode), rand_coord(mode), rand_coord(mode),
                       rand_coord(mode), rand_coord(mode));
         // occasionally force parallel or degenerate segments
         if ($urandom_range(0, 9) == 0) begin
            s.dx = s.cx + (s.bx - s.ax);
            s.dy = s.cy + (s.by_coord - s.ay);
         end else if ($urandom_range(0, 19) == 0) begin
            s.bx = s.ax;
            s.by_coord = s.ay;
         end
         pending_pairs.push_back(s);
      end
   end

   // reset, then wait until every item is sent and every result is checked
   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      wait (pending_pairs.size() == 0);
      @(posedge clock);
      wait (!req.valid);
      @(posedge clock);
      wait (expected_crossings.size() == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("end of test: mismatches");
         $finish;
      end
   end

   // driver: bursts of items with random gaps
   int burst_left = 0;
   int gap_left = 0;
   initial begin
      req.valid = 1'b0;
      {req.ax, req.ay, req.bx, req.by_coord, req.cx, req.cy, req.dx, req.dy} = '0;
   end
   always @(posedge clock) begin
      seg_pair_type s;
      bit take;
      if (!reset) begin
         take = !req.valid || req.ready;
         if (req.valid && req.ready) begin
            expected_crossings.push_back(predict_crossing(
               make_pair(req.ax, req.ay, req.bx, req.by_coord,
                         req.cx, req.cy, req.dx, req.dy)));
         end
         if (take) begin
            if (gap_left > 0) begin
               gap_left <= gap_left - 1;
               req.valid <= 1'b0;
            end else if (pending_pairs.size() > 0) begin
               s = pending_pairs.pop_front();
               req.valid <= 1'b1;
               req.ax <= s.ax; req.ay <= s.ay; req.bx <= s.bx; req.by_coord <= s.by_coord;
               req.cx <= s.cx; req.cy <= s.cy; req.dx <= s.dx; req.dy <= s.dy;
               if (burst_left > 0) begin
                  burst_left <= burst_left - 1;
               end else begin
                  burst_left <= $urandom_range(0, 40);
                  gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
               end
            end else begin
               req.valid <= 1'b0;
            end
         end
      end
   end

   // receiver stall pattern, with one long hold-off to back up the pipeline
   initial rsp.ready = 1'b0;
   always @(posedge clock) begin
      if (reset) begin
         rsp.ready <= 1'b0;
      end else if (cycle_count == 300) begin
         hold_off <= 200;
         rsp.ready <= 1'b0;
      end else if (hold_off > 0) begin
         hold_off <= hold_off - 1;
         rsp.ready <= (hold_off == 1);
      end else if ((cycle_count / 64) % 3 == 0) begin
         rsp.ready <= 1'b1;
      end else begin
         rsp.ready <= ($urandom_range(0, 3) != 0);
      end
   end

   // monitor: compare each result with the oldest expectation
   always @(posedge clock) begin
      crossing_type want;
      if (!reset && rsp.valid && rsp.ready) begin
         if (expected_crossings.size() == 0) begin
            $error("unexpected result item");
            error_count = error_count + 1;
         end else begin
            want = expected_crossings.pop_front();
            if (rsp.cross_x !== want.cross_x) begin
               $error("cross_x expected %0d got %0d", want.cross_x, rsp.cross_x);
               error_count = error_count + 1;
            end
            if (rsp.cross_y !== want.cross_y) begin
               $error("cross_y expected %0d got %0d", want.cross_y, rsp.cross_y);
               error_count = error_count + 1;
            end
            if (rsp.outcome !== want.outcome) begin
               $error("outcome expected %0d got %0d", want.outcome, rsp.outcome);
               error_count = error_count + 1;
            end
            if (rsp.clipped !== want.clipped) begin
               $error("clipped expected %0d got %0d", want.clipped, rsp.clipped);
               error_count = error_count + 1;
            end
         end
      end
   end

endmodule
`default_nettype wire

// ===== filelist.f =====
hw/rtl/sgi_pkg.sv
hw/rtl/sgi_req_if.sv
hw/rtl/sgi_rsp_if.sv
hw/rtl/sgi_front.sv
hw/rtl/sgi_div_cell.sv
hw/rtl/segment_intersection_unit.sv
bench/tb_segment_intersection_unit.sv
